>>> rtl/core/gcr_pkg.sv
// Shared types, constants and the sine table of the grid ray caster.
`default_nettype none
package gcr_pkg;

  // Map geometry.
  localparam int MAP_DIM    = 64;
  localparam int MAP_BITS   = $clog2(MAP_DIM);
  localparam int MAP_ADDR_W = 2 * MAP_BITS;
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;

  // Sine table, one full turn of SINE_TABLE_SIZE entries, stored as a quarter wave.
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
  localparam int SINE_QTR        = SINE_TABLE_SIZE / 4;
  localparam int QTR_BITS        = SINE_BITS - 2;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Depth reported by an axis whose direction component is zero.
  localparam logic [39:0] DEPTH_CAP  = '1;
  // 0.0001 in Q16, added to the depth before the height division.
  localparam logic [40:0] HEIGHT_EPS = 41'd7;

  // Divider widths.
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 41;
  localparam int DIV_CNT_W = 6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_MAP_WIDTH   = 3'd0,
    CFG_MAP_HEIGHT  = 3'd1,
    CFG_HALF_FOV    = 3'd2,
    CFG_RAY_STEP    = 3'd3,
    CFG_SCREEN_DIST = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    op_t         operation;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  cell_value;
    logic [21:0] origin_x;
    logic [21:0] origin_y;
    logic [23:0] view_angle;
    logic [8:0]  ray_index;
  } in_t;

  typedef struct packed {
    logic [23:0] wall_depth;
    logic [19:0] column_height;
    logic [7:0]  texture_id;
    logic [15:0] texture_offset;
  } out_t;

  // Sine or cosine as sign and Q1.16 magnitude.
  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
  } trig_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANGLE,
    ST_TRIG,
    ST_AX_SETUP,
    ST_DIV_D0,
    ST_DIV_DD,
    ST_MUL_A_LO,
    ST_MUL_A_HI,
    ST_MUL_B_LO,
    ST_MUL_B_HI,
    ST_STEP,
    ST_READ,
    ST_AX_DONE,
    ST_PICK,
    ST_FISH_LO,
    ST_FISH_HI,
    ST_HT_START,
    ST_DIV_HT,
    ST_OUT
  } state_t;

  typedef logic [16:0] qtab_t [0:SINE_QTR];

  // Builds the quarter-wave table with a fixed-point Taylor series at elaboration.
  function automatic qtab_t build_qtab();
    qtab_t tab;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    for (int j = 0; j <= SINE_QTR; j++) begin
      r  = longint'(j) * ((64'd1 << 22) / SINE_QTR);
      x  = (r * HALF_PI_Q30) >> 22;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      v  = (((x * t) >> 30) + 64'd8192) >> 14;
      if (v > 64'd65536) v = 64'd65536;
      tab[j] = v[16:0];
    end
    return tab;
  endfunction

  localparam qtab_t SINE_QTAB = build_qtab();

  // Sine of a 24-bit turn angle through the quarter-wave table.
  function automatic trig_t sine_lookup(logic [23:0] a);
    logic [SINE_BITS-1:0] k;
    logic [QTR_BITS:0]    j;
    trig_t                res;
    k = a[23 -: SINE_BITS];
    if (k[QTR_BITS]) begin
      j = (QTR_BITS+1)'(SINE_QTR) - {1'b0, k[QTR_BITS-1:0]};
    end else begin
      j = {1'b0, k[QTR_BITS-1:0]};
    end
    res.neg = k[SINE_BITS-1];
    res.mag = SINE_QTAB[j];
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/gcr_map_ram.sv
// Tile map memory: one write port, one read port with registered read data.
`default_nettype none
module gcr_map_ram
  import gcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [MAP_ADDR_W-1:0] waddr,
  input  logic [7:0]            wdata,
  input  logic [MAP_ADDR_W-1:0] raddr,
  output logic [7:0]            rdata
);

  logic [7:0] mem [MAP_DEPTH];
  logic [7:0] rdata_r;

  // Write and synchronous read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/core/gcr_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module gcr_div
  import gcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // Control: iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/grid_ray_caster_core.sv
// Top level of the grid ray caster: sequencer, walk datapath, map memory and divider.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall   | in_data (in_t): map write or ray cast
//  out_    | output    | out_valid/out_stall | out_data (out_t): one result per cast
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// A map write leaves the block idle. A cast steps once for each grid line crossed outside
// the map and steps and reads the map for each one inside it; up to five divisions on the
// shared one-bit-per-cycle divider and the single map read port set its length. One cast
// is in flight at a time. After reset a clearing pass zeroes all 4096 map cells with in_stall
// high. A finished result waits in the output register while the next item is accepted.
`default_nettype none
module grid_ray_caster_core
  import gcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_wdata
);

  // Configuration registers.
  logic [6:0]  map_w_r;
  logic [6:0]  map_h_r;
  logic [22:0] half_fov_r;
  logic [15:0] ray_step_r;
  logic [15:0] scr_dist_r;

  // Sequencer.
  state_t state_r;
  state_t state_nxt;
  logic [MAP_ADDR_W-1:0] clr_addr_r;

  // Cast operands and per-ray values.
  logic [21:0] ox_r;
  logic [21:0] oy_r;
  logic [23:0] view_r;
  logic [8:0]  idx_r;
  logic [23:0] ray_r;
  trig_t       s_r;
  trig_t       c_r;
  trig_t       cf_r;
  logic        axis_r;

  // Walk state.
  logic [32:0]       d0_r;
  logic [32:0]       dd_r;
  logic [56:0]       mul_acc_r;
  logic [56:0]       prod_r;
  logic [56:0]       ddc_r;
  logic [39:0]       d_r;
  logic [6:0]        i_r;
  logic signed [8:0] m_r;
  logic [7:0]        tex_r;

  // Per-axis results and the chosen hit.
  logic [39:0] dh_r;
  logic [15:0] fh_r;
  logic [7:0]  th_r;
  logic [39:0] dv_r;
  logic [15:0] fv_r;
  logic [7:0]  tv_r;
  logic [39:0] sel_depth_r;
  logic [7:0]  sel_tex_r;
  logic [15:0] sel_off_r;
  logic [39:0] corr_r;

  logic out_valid_r;
  out_t out_data_r;

  // Combinational signals.
  logic [6:0]  map_w;
  logic [6:0]  map_h;
  logic [21:0] o_main;
  logic [21:0] o_cross;
  trig_t       sm;
  trig_t       sc;
  logic [6:0]  n_main;
  logic [6:0]  n_cross;
  logic        sm_zero;
  logic        main_pos;
  logic [5:0]  c_main;
  logic [16:0] dist0;
  logic [40:0] off;
  logic [42:0] pcur;
  logic        in_map;
  logic        walk_end;
  logic [MAP_ADDR_W-1:0] step_addr;
  logic [15:0] f_cur;
  logic        c_pos;
  logic        s_pos;
  logic        cf_pos;
  logic [39:0] mul_a;
  logic [16:0] mul_b;
  logic        hi_phase;
  logic [19:0] mul_half;
  logic [36:0] mul_p;
  logic [56:0] mul_full;
  logic        in_acc;
  logic        out_load;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        ram_we;
  logic [MAP_ADDR_W-1:0] ram_waddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r    <= 7'd64;
      map_h_r    <= 7'd64;
      half_fov_r <= 23'd1398101;
      ray_step_r <= 16'd8738;
      scr_dist_r <= 16'd8868;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:   map_w_r    <= cfg_wdata[6:0];
        CFG_MAP_HEIGHT:  map_h_r    <= cfg_wdata[6:0];
        CFG_HALF_FOV:    half_fov_r <= cfg_wdata;
        CFG_RAY_STEP:    ray_step_r <= cfg_wdata[15:0];
        CFG_SCREEN_DIST: scr_dist_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Map size clamp and the axis being walked.
  always_comb begin
    map_w    = (map_w_r > 7'(MAP_DIM)) ? 7'(MAP_DIM) : map_w_r;
    map_h    = (map_h_r > 7'(MAP_DIM)) ? 7'(MAP_DIM) : map_h_r;
    o_main   = axis_r ? ox_r : oy_r;
    o_cross  = axis_r ? oy_r : ox_r;
    sm       = axis_r ? c_r : s_r;
    sc       = axis_r ? s_r : c_r;
    n_main   = axis_r ? map_w : map_h;
    n_cross  = axis_r ? map_h : map_w;
    sm_zero  = (sm.mag == '0);
    main_pos = !sm.neg;
    c_main   = o_main[21:16];
    dist0    = main_pos ? (17'h10000 - {1'b0, o_main[15:0]}) : {1'b0, o_main[15:0]};
  end

  // Current step: cross position, map bounds and memory address.
  always_comb begin
    off      = prod_r[56:16];
    pcur     = sc.neg ? ({21'b0, o_cross} - {2'b0, off}) : ({21'b0, o_cross} + {2'b0, off});
    walk_end = (i_r >= n_main);
    in_map   = !m_r[8] && (m_r[7:0] < {1'b0, n_main}) && !pcur[42] &&
               (pcur[41:16] < {19'b0, n_cross});
    step_addr = axis_r ? {pcur[16 +: MAP_BITS], m_r[MAP_BITS-1:0]}
                       : {m_r[MAP_BITS-1:0], pcur[16 +: MAP_BITS]};
    f_cur    = sm_zero ? 16'h0 : pcur[15:0];
    c_pos    = !c_r.neg && (c_r.mag != '0);
    s_pos    = !s_r.neg && (s_r.mag != '0);
    cf_pos   = !cf_r.neg && (cf_r.mag != '0);
  end

  // Shared multiplier: 40 x 17 bits in two halves, low half first.
  always_comb begin
    hi_phase = (state_r == ST_MUL_A_HI) || (state_r == ST_MUL_B_HI) ||
               (state_r == ST_FISH_HI);
    if ((state_r == ST_MUL_A_LO) || (state_r == ST_MUL_A_HI)) begin
      mul_a = {7'b0, d0_r};
    end else if ((state_r == ST_MUL_B_LO) || (state_r == ST_MUL_B_HI)) begin
      mul_a = {7'b0, dd_r};
    end else begin
      mul_a = sel_depth_r;
    end
    mul_b    = ((state_r == ST_FISH_LO) || (state_r == ST_FISH_HI)) ? cf_r.mag : sc.mag;
    mul_half = hi_phase ? mul_a[39:20] : mul_a[19:0];
    mul_p    = {17'b0, mul_half} * {20'b0, mul_b};
    mul_full = mul_acc_r + {mul_p, 20'b0};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_addr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid && (in_data.operation == OP_CAST)) state_nxt = ST_ANGLE;
      ST_ANGLE:    state_nxt = ST_TRIG;
      ST_TRIG:     state_nxt = ST_AX_SETUP;
      ST_AX_SETUP: state_nxt = sm_zero ? ST_AX_DONE : ST_DIV_D0;
      ST_DIV_D0:   if (div_rsp.done) state_nxt = ST_DIV_DD;
      ST_DIV_DD:   if (div_rsp.done) state_nxt = ST_MUL_A_LO;
      ST_MUL_A_LO: state_nxt = ST_MUL_A_HI;
      ST_MUL_A_HI: state_nxt = ST_MUL_B_LO;
      ST_MUL_B_LO: state_nxt = ST_MUL_B_HI;
      ST_MUL_B_HI: state_nxt = ST_STEP;
      ST_STEP: begin
        if (walk_end) begin
          state_nxt = ST_AX_DONE;
        end else if (in_map) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:     state_nxt = (ram_rdata != 8'd0) ? ST_AX_DONE : ST_STEP;
      ST_AX_DONE:  state_nxt = axis_r ? ST_PICK : ST_AX_SETUP;
      ST_PICK:     state_nxt = ST_FISH_LO;
      ST_FISH_LO:  state_nxt = ST_FISH_HI;
      ST_FISH_HI:  state_nxt = ST_HT_START;
      ST_HT_START: state_nxt = ST_DIV_HT;
      ST_DIV_HT:   if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_acc    = in_valid && (state_r == ST_IDLE);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
    ram_we    = (state_r == ST_CLEAR) || (in_acc && (in_data.operation == OP_WRITE));
    ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : {in_data.cell_y, in_data.cell_x};
    ram_wdata = (state_r == ST_CLEAR) ? 8'd0 : in_data.cell_value;
    div_req.start = ((state_r == ST_AX_SETUP) && !sm_zero) ||
                    ((state_r == ST_DIV_D0) && div_rsp.done) ||
                    (state_r == ST_HT_START);
    if (state_r == ST_AX_SETUP) begin
      div_req.num = {dist0, 16'b0};
    end else if (state_r == ST_DIV_D0) begin
      div_req.num = 33'h1_0000_0000;
    end else begin
      div_req.num = {1'b0, scr_dist_r, 16'b0};
    end
    div_req.den = (state_r == ST_HT_START) ? ({1'b0, corr_r} + HEIGHT_EPS)
                                            : {24'b0, sm.mag};
  end

  // State register and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Cast datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ox_r   <= in_data.origin_x;
        oy_r   <= in_data.origin_y;
        view_r <= in_data.view_angle;
        idx_r  <= in_data.ray_index;
      end
      ST_ANGLE: begin
        ray_r <= view_r - {1'b0, half_fov_r} + ({15'b0, idx_r} * {8'b0, ray_step_r});
      end
      ST_TRIG: begin
        s_r    <= sine_lookup(ray_r);
        c_r    <= sine_lookup(ray_r + 24'h400000);
        cf_r   <= sine_lookup(view_r - ray_r + 24'h400000);
        axis_r <= 1'b0;
      end
      ST_AX_SETUP: begin
        // A zero direction component saturates this axis with no hit.
        d_r   <= DEPTH_CAP;
        tex_r <= 8'd0;
      end
      ST_DIV_D0: begin
        if (div_rsp.done) d0_r <= div_rsp.quo;
      end
      ST_DIV_DD: begin
        if (div_rsp.done) dd_r <= div_rsp.quo;
      end
      ST_MUL_A_LO, ST_MUL_B_LO, ST_FISH_LO: begin
        mul_acc_r <= {20'b0, mul_p};
      end
      ST_MUL_A_HI: begin
        prod_r <= mul_full;
      end
      ST_MUL_B_HI: begin
        ddc_r <= mul_full;
        d_r   <= {7'b0, d0_r};
        i_r   <= 7'd0;
        m_r   <= main_pos ? ($signed({3'b0, c_main}) + 9'sd1)
                          : ($signed({3'b0, c_main}) - 9'sd1);
        tex_r <= 8'd0;
      end
      ST_STEP: begin
        if (!walk_end && !in_map) begin
          d_r    <= d_r + {7'b0, dd_r};
          prod_r <= prod_r + ddc_r;
          i_r    <= i_r + 7'd1;
          m_r    <= main_pos ? (m_r + 9'sd1) : (m_r - 9'sd1);
        end
      end
      ST_READ: begin
        if (ram_rdata != 8'd0) begin
          tex_r <= ram_rdata;
        end else begin
          d_r    <= d_r + {7'b0, dd_r};
          prod_r <= prod_r + ddc_r;
          i_r    <= i_r + 7'd1;
          m_r    <= main_pos ? (m_r + 9'sd1) : (m_r - 9'sd1);
        end
      end
      ST_AX_DONE: begin
        if (axis_r) begin
          dv_r <= d_r;
          fv_r <= f_cur;
          tv_r <= tex_r;
        end else begin
          dh_r   <= d_r;
          fh_r   <= f_cur;
          th_r   <= tex_r;
          axis_r <= 1'b1;
        end
      end
      ST_PICK: begin
        // The vertical hit wins only when strictly nearer.
        if (dv_r < dh_r) begin
          sel_depth_r <= dv_r;
          sel_tex_r   <= tv_r;
          sel_off_r   <= c_pos ? fv_r : (16'h0 - fv_r);
        end else begin
          sel_depth_r <= dh_r;
          sel_tex_r   <= th_r;
          sel_off_r   <= s_pos ? (16'h0 - fh_r) : fh_r;
        end
      end
      ST_FISH_HI: begin
        corr_r <= cf_pos ? mul_full[55:16] : 40'd0;
      end
      ST_OUT: begin
        if (out_load) begin
          out_data_r.wall_depth     <= (corr_r > 40'hFF_FFFF) ? 24'hFF_FFFF : corr_r[23:0];
          out_data_r.column_height  <= (div_rsp.quo > 33'hF_FFFF) ? 20'hF_FFFF
                                                                  : div_rsp.quo[19:0];
          out_data_r.texture_id     <= sel_tex_r;
          out_data_r.texture_offset <= sel_off_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  gcr_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (step_addr),
    .rdata (ram_rdata)
  );

  gcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire

>>> rtl/core/gcr_checker.sv
// Port-level checks of the grid ray caster and their binding to the top level.
`default_nettype none
module gcr_checker
  import gcr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input in_t         in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_t        out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The map clearing pass follows reset with the input stalled.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // A cast occupies the block for the following cycle.
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_CAST) |=> in_stall)
    else $error("cast did not occupy the block");

  // A map write does not hold the input.
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_WRITE) |=> !in_stall)
    else $error("map write held the input");

endmodule

bind grid_ray_caster_core gcr_checker u_gcr_checker (.*);
`default_nettype wire

>>> tb/grid_ray_caster_core_checker.sv
// Checker for the grid ray caster: watches the channels, predicts each cast result and compares.
`timescale 1ns / 100ps
module grid_ray_caster_core_checker
  import gcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam longint DEPTH_SAT = 64'hFF_FFFF_FFFF;

  // Shadow copy of the tile map and of the registers.
  logic [7:0]  tiles [0:MAP_DEPTH-1];
  logic [6:0]  cols_used, rows_used;
  logic [22:0] fov_half;
  logic [15:0] ray_step, proj_dist;

  out_t cast_results_q [$];

  assign pending = cast_results_q.size();

  // Sine of a turn angle in Q1.16, taken from the table entry the angle falls in.
  function automatic longint trig_q16(logic [23:0] a);
    logic [23:0]      phase;
    longint unsigned  r, x, x2, t, v;
    longint unsigned  divs [5];
    divs = '{110, 72, 42, 20, 6};
    phase = {a[23:14], 14'd0};
    r = phase[21:0];
    if (phase[22]) r = (64'd1 << 22) - r;
    x  = (r * 64'd1686629713) >> 22;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
    v = (((x * t) >> 30) + 64'd8192) >> 14;
    if (v > 64'd65536) v = 64'd65536;
    return phase[23] ? -longint'(v) : longint'(v);
  endfunction

  // Walks one axis until a nonzero cell or the step count runs out.
  task automatic walk_lines(input longint o_main, input longint o_cross,
                            input longint s_main, input longint s_cross,
                            input longint n_main, input longint n_cross, input bit horiz,
                            output longint depth, output longint pos, output logic [7:0] tex);
    longint c_main, mag, cmag, dist0, d0, dd, d, off, p, m;
    logic [7:0] v;
    bit done;
    tex = 8'd0;
    depth = DEPTH_SAT;
    pos = 0;
    if (s_main != 0) begin
      c_main = o_main >> 16;
      mag = s_main < 0 ? -s_main : s_main;
      cmag = s_cross < 0 ? -s_cross : s_cross;
      dist0 = s_main > 0 ? ((c_main + 1) << 16) - o_main : o_main - (c_main << 16);
      d0 = (dist0 << 16) / mag;
      dd = (64'd1 << 32) / mag;
      done = 1'b0;
      for (longint i = 0; !done; i++) begin
        d = d0 + i * dd;
        off = (d * cmag) >> 16;
        p = s_cross >= 0 ? o_cross + off : o_cross - off;
        m = s_main > 0 ? c_main + 1 + i : c_main - 1 - i;
        depth = d;
        pos = p;
        if (i >= n_main) begin
          done = 1'b1;
        end else if (m >= 0 && m < n_main && p >= 0 && (p >> 16) < n_cross) begin
          v = horiz ? tiles[m * MAP_DIM + (p >> 16)] : tiles[(p >> 16) * MAP_DIM + m];
          if (v != 0) begin
            tex = v;
            done = 1'b1;
          end
        end
      end
    end
  endtask

  // Full cast: ray angle, both axis walks, nearer hit, fisheye correction and height.
  task automatic cast_ray(input in_t item, output out_t res);
    logic [23:0] ray, fish;
    longint      w, h, s, c, cf, dh, dv, xh, yv, depth, corr, height, f, offset;
    logic [7:0]  th, tv, tex;
    w = cols_used > MAP_DIM ? MAP_DIM : cols_used;
    h = rows_used > MAP_DIM ? MAP_DIM : rows_used;
    ray = item.view_angle - fov_half[22:0] + item.ray_index * ray_step;
    s = trig_q16(ray);
    c = trig_q16(ray + 24'h400000);
    walk_lines(item.origin_y, item.origin_x, s, c, h, w, 1'b1, dh, xh, th);
    walk_lines(item.origin_x, item.origin_y, c, s, w, h, 1'b0, dv, yv, tv);
    if (dv < dh) begin
      depth = dv;
      tex = tv;
      f = yv & 64'hFFFF;
      offset = c > 0 ? f : ((64'h10000 - f) & 64'hFFFF);
    end else begin
      depth = dh;
      tex = th;
      f = xh & 64'hFFFF;
      offset = s > 0 ? ((64'h10000 - f) & 64'hFFFF) : f;
    end
    fish = item.view_angle - ray;
    cf = trig_q16(fish + 24'h400000);
    corr = cf > 0 ? (depth * cf) >> 16 : 0;
    height = (longint'(proj_dist) << 16) / (corr + 7);
    res.wall_depth = corr > 64'hFFFFFF ? 24'hFFFFFF : corr[23:0];
    res.column_height = height > 64'hFFFFF ? 20'hFFFFF : height[19:0];
    res.texture_id = tex;
    res.texture_offset = offset[15:0];
  endtask

  // Input transactions and register writes update the shadow state.
  always @(posedge clk) begin
    out_t res;
    if (!rst_n) begin
      for (int i = 0; i < MAP_DEPTH; i++) tiles[i] <= 8'd0;
      cols_used   <= 7'd64;
      rows_used   <= 7'd64;
      fov_half    <= 23'd1398101;
      ray_step    <= 16'd8738;
      proj_dist   <= 16'd8868;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAP_WIDTH:   cols_used   <= cfg_wdata[6:0];
          CFG_MAP_HEIGHT:  rows_used   <= cfg_wdata[6:0];
          CFG_HALF_FOV:    fov_half    <= cfg_wdata;
          CFG_RAY_STEP:    ray_step    <= cfg_wdata[15:0];
          CFG_SCREEN_DIST: proj_dist   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_WRITE) begin
          tiles[in_data.cell_y * MAP_DIM + in_data.cell_x] <= in_data.cell_value;
        end else begin
          cast_ray(in_data, res);
          cast_results_q.push_back(res);
        end
      end
    end
  end

  // Result transactions are compared with the oldest prediction.
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      errors = 0;
    end else if (out_valid && !out_stall) begin
      if (cast_results_q.size() == 0) begin
        $error("unexpected result transaction %h", out_data);
        errors++;
      end else begin
        exp_res = cast_results_q.pop_front();
        if (out_data.wall_depth !== exp_res.wall_depth) begin
          $error("wall_depth: expected %h, actual %h", exp_res.wall_depth, out_data.wall_depth);
          errors++;
        end
        if (out_data.column_height !== exp_res.column_height) begin
          $error("column_height: expected %h, actual %h",
                 exp_res.column_height, out_data.column_height);
          errors++;
        end
        if (out_data.texture_id !== exp_res.texture_id) begin
          $error("texture_id: expected %h, actual %h", exp_res.texture_id, out_data.texture_id);
          errors++;
        end
        if (out_data.texture_offset !== exp_res.texture_offset) begin
          $error("texture_offset: expected %h, actual %h",
                 exp_res.texture_offset, out_data.texture_offset);
          errors++;
        end
      end
    end
  end

endmodule

>>> tb/grid_ray_caster_core_tb.sv
// Top of the grid ray caster testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module grid_ray_caster_core_tb;
  import gcr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_wdata = '0;
  int          errors, pending;

  // Idle modes: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
  int idle_mode = 0;
  logic [6:0] cur_w = 7'd64, cur_h = 7'd64;

  grid_ray_caster_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  grid_ray_caster_core_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver stalls at random according to the idle mode.
  always @(posedge clk) begin
    case (idle_mode)
      2: out_stall <= $urandom_range(99) < 87;
      3: out_stall <= $urandom_range(99) < 21;
      default: out_stall <= 1'b0;
    endcase
  end

  // Offers one transaction and holds it until the block takes it.
  task automatic issue_item(input in_t item);
    bit taken;
    int gap_pct;
    gap_pct = idle_mode == 1 ? 87 : (idle_mode == 3 ? 21 : 0);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic in_t map_write(int x, int y, int v);
    in_t          item;
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    item = noise[$bits(in_t)-1:0];
    item.operation  = OP_WRITE;
    item.cell_x     = 6'(x);
    item.cell_y     = 6'(y);
    item.cell_value = 8'(v);
    return item;
  endfunction

  function automatic in_t cast_req(int ox, int oy, int view, int idx);
    in_t          item;
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    item = noise[$bits(in_t)-1:0];
    item.operation  = OP_CAST;
    item.origin_x   = 22'(ox);
    item.origin_y   = 22'(oy);
    item.view_angle = 24'(view);
    item.ray_index  = 9'(idx);
    return item;
  endfunction

  // Registers change only once every result is back and a pending map write has landed.
  task automatic write_regs(input int w, input int h, input int fov, input int stp, input int sd);
    logic [22:0] vals [5];
    vals = '{23'(w), 23'(h), 23'(fov), 23'(stp), 23'(sd)};
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_w = 7'(w);
    cur_h = 7'(h);
  endtask

  // Mostly casts from inside the map in use over a sparse map, with some writes and noise.
  task automatic random_phase(input int count);
    int wx, hy, ox, oy;
    for (int n = 0; n < count; n++) begin
      wx = cur_w == 0 ? 1 : (cur_w > 64 ? 64 : cur_w);
      hy = cur_h == 0 ? 1 : (cur_h > 64 ? 64 : cur_h);
      if ($urandom_range(99) < 30) begin
        issue_item(map_write($urandom_range(63), $urandom_range(63),
                             $urandom_range(3) == 0 ? 0 : $urandom_range(255)));
      end else begin
        if ($urandom_range(9) == 0) begin
          ox = $urandom_range(22'h3FFFFF);
          oy = $urandom_range(22'h3FFFFF);
        end else begin
          ox = $urandom_range(wx * 65536 - 1);
          oy = $urandom_range(hy * 65536 - 1);
        end
        if ($urandom_range(7) == 0) ox = ox & ~32'hFFFF;
        issue_item(cast_req(ox, oy, $urandom_range(24'hFFFFFF), $urandom_range(511)));
      end
      // The sender holds off now and then until the block has drained.
      if ($urandom_range(99) == 0) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: map corners, axis-aligned rays, extreme origins and angles.
    issue_item(map_write(0, 0, 255));
    issue_item(map_write(63, 63, 1));
    issue_item(map_write(63, 0, 128));
    issue_item(map_write(0, 63, 127));
    issue_item(map_write(10, 5, 9));
    issue_item(cast_req(0, 0, 1398101, 0));
    issue_item(cast_req(22'h3FFFFF, 22'h3FFFFF, 0, 511));
    issue_item(cast_req(5 << 16, 5 << 16, 1398101 + 24'h400000, 0));
    issue_item(cast_req(5 << 16, 5 << 16, 1398101 + 24'h800000, 0));
    issue_item(cast_req(5 << 16, 5 << 16, 1398101 + 24'hC00000, 0));
    issue_item(cast_req(32 << 16, 5 << 16, 24'hFFFFFF, 160));
    issue_item(cast_req(20 << 16, 20 << 16, 0, 0));
    issue_item(cast_req(1 << 16, 1 << 16, 24'hA00000, 80));
    issue_item(map_write(0, 0, 0));
    issue_item(cast_req(1 << 16, 1 << 16, 24'hA00000, 80));
    issue_item(cast_req(0, 22'h3FFFFF, 24'h123456, 511));

    // Phases over register settings and idle modes.
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        1: write_regs(1, 1, 0, 0, 0);
        2: write_regs(64, 64, 4194304, 65535, 65535);
        3: write_regs(127, 0, $urandom_range(4194304), $urandom_range(65535), 65535);
        4: write_regs(0, 127, $urandom_range(4194304), $urandom_range(65535),
                      $urandom_range(65535));
        5: write_regs($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(4194304),
                      $urandom_range(65535), $urandom_range(65535));
        default: ;
      endcase
      random_phase(190);
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
